### design/manchester_byte_transmitter_macros.svh
// Assertion macros shared by the Manchester transmitter RTL.
// Each file that asserts includes this header; it needs clk_i and rst_ni in scope.
`ifndef MANCHESTER_BYTE_TRANSMITTER_MACROS_SVH
`define MANCHESTER_BYTE_TRANSMITTER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define MBT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define MBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mbt_pkg.sv
// Shared types and constants of the Manchester byte transmitter.
// No dependencies; every RTL module imports this package.
`default_nettype none

package mbt_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int TICK_W      = 16;
  localparam int HALVES_W    = 5;
  localparam int COUNT_W     = 4;
  localparam int DATA_W      = 8;

  localparam logic [TICK_W-1:0]   HALF_BIT_TICKS_RESET = 16'd487;
  localparam logic [HALVES_W-1:0] HALVES_PER_BYTE      = 5'd16;

  // Command queue between the front and the back.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
  } cmd_t;

  function automatic logic [QPTR_W-1:0] ring_next(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/manchester_byte_transmitter.sv
// Top level of the Manchester byte transmitter: front stage, command queue, back end.
// Depends on mbt_pkg, mbt_front, mbt_cmd_fifo and mbt_back.
//
//   Channel   Direction  Handshake               Fields
//   in        input      in_valid_i/in_stall_o   operation_i, data_byte_i
//   out       output     out_valid_o/out_stall_i line_level_o, push_accepted_o,
//                                                 sending_o, queued_bytes_o
//   cfg       input      cfg_we_i                cfg_wdata_i (half_bit_ticks)
//
// One word per clock is sustained while the output is not stalled; each word's state
// update is made by the back end's serializer logic. A word passes the front
// register, the command queue and the result register before its result is valid.
// Reset is asynchronous and active low: the line idles high, half_bit_ticks is 487.
// A stalled output holds the back end; the command queue then fills and stalls the input.
`default_nettype none

module manchester_byte_transmitter import mbt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TICK_W-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               operation_i,
  input  wire logic [DATA_W-1:0]  data_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    line_level_o,
  output logic                    push_accepted_o,
  output logic                    sending_o,
  output logic [COUNT_W-1:0]      queued_bytes_o
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_pop;
  cmd_t bk_cmd;

  mbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  mbt_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_cmd_i   (fr_cmd),
    .rd_valid_o (bk_valid),
    .rd_pop_i   (bk_pop),
    .rd_cmd_o   (bk_cmd)
  );

  mbt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_valid_i     (bk_valid),
    .cmd_pop_o       (bk_pop),
    .cmd_i           (bk_cmd),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_level_o    (line_level_o),
    .push_accepted_o (push_accepted_o),
    .sending_o       (sending_o),
    .queued_bytes_o  (queued_bytes_o)
  );

endmodule

`default_nettype wire

### design/mbt_front.sv
// Front stage: registers an incoming word and classifies it as push or tick.
// Depends on mbt_pkg.
`default_nettype none

module mbt_front import mbt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              operation_i,
  input  wire logic [DATA_W-1:0] data_byte_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output cmd_t                   cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign in_stall_o = valid_q && !cmd_ready_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (take) begin
      valid_d    = 1'b1;
      cmd_d.op   = operation_i ? OP_TICK : OP_PUSH;
      cmd_d.data = data_byte_i;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

### design/mbt_cmd_fifo.sv
// Short command queue that decouples the front stage from the serializer.
// Depends on mbt_pkg.
`default_nettype none

module mbt_cmd_fifo import mbt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  input  wire cmd_t wr_cmd_i,
  output logic      rd_valid_o,
  input  wire logic rd_pop_i,
  output cmd_t      rd_cmd_o
);

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_PTR_W:0]   count_q, count_d;
  logic                  push, pop;

  assign wr_ready_o = (count_q != (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + CMDQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + CMDQ_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + (CMDQ_PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (CMDQ_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

`default_nettype wire

### design/mbt_back.sv
// Back end: byte ring queue, half-bit timer, Manchester serializer and result register.
// Depends on mbt_pkg and manchester_byte_transmitter_macros.svh.
`default_nettype none
`include "manchester_byte_transmitter_macros.svh"

module mbt_back import mbt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TICK_W-1:0]  cfg_wdata_i,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_pop_o,
  input  wire cmd_t               cmd_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    line_level_o,
  output logic                    push_accepted_o,
  output logic                    sending_o,
  output logic [COUNT_W-1:0]      queued_bytes_o
);

  logic [DATA_W-1:0]   queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head_q, head_d;
  logic [QPTR_W-1:0]   tail_q, tail_d;
  logic [DATA_W-1:0]   shift_q, shift_d;
  logic [HALVES_W-1:0] halves_q, halves_d;
  logic                busy_q, busy_d;
  logic                line_q, line_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [TICK_W-1:0]   hbt_q;

  logic                out_valid_q;
  logic                out_line_q;
  logic                out_acc_q;
  logic                out_busy_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic                take;
  logic                accept;
  logic [QPTR_W:0]     count_full;

  assign take      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = take;

  always_comb begin
    logic [QPTR_W-1:0]   tail_nxt;
    logic [TICK_W-1:0]   tick_inc;
    logic [DATA_W-1:0]   load_byte;
    logic                run_slot;
    logic [HALVES_W-1:0] halves_s;
    head_d   = head_q;
    tail_d   = tail_q;
    shift_d  = shift_q;
    halves_d = halves_q;
    busy_d   = busy_q;
    line_d   = line_q;
    tick_d   = tick_q;
    accept   = 1'b0;
    run_slot = 1'b0;
    halves_s = halves_q;
    tail_nxt = ring_next(tail_q);
    tick_inc = tick_q + TICK_W'(1);
    // A byte pushed into an empty queue is loaded straight from the input.
    load_byte = (cmd_i.op == OP_PUSH && head_q == tail_q) ? cmd_i.data : queue_q[head_q];

    if (take) begin
      if (cmd_i.op == OP_PUSH) begin
        accept = (tail_nxt != head_q);
        if (accept) begin
          tail_d = tail_nxt;
        end
        if (!busy_q) begin
          busy_d   = 1'b1;
          line_d   = ~line_q;
          halves_s = '0;
          tick_d   = '0;
          run_slot = 1'b1;
        end
      end else if (busy_q) begin
        if (tick_inc >= hbt_q) begin
          tick_d   = '0;
          run_slot = 1'b1;
        end else begin
          tick_d = tick_inc;
        end
      end
    end

    if (run_slot) begin
      if (halves_s != '0) begin
        // Even count: first half drives the inverted bit; odd: the true bit.
        if (!halves_s[0]) begin
          line_d = ~shift_q[0];
        end else begin
          line_d  = shift_q[0];
          shift_d = shift_q >> 1;
        end
        halves_d = halves_s - HALVES_W'(1);
      end else if (head_q == tail_d) begin
        busy_d   = 1'b0;
        halves_d = '0;
      end else begin
        shift_d  = load_byte;
        head_d   = ring_next(head_q);
        halves_d = HALVES_PER_BYTE;
      end
    end
  end

  always_comb begin
    if (tail_d >= head_d) begin
      count_full = {1'b0, tail_d} - {1'b0, head_d};
    end else begin
      count_full = {1'b0, tail_d} + (QPTR_W+1)'(QUEUE_DEPTH) - {1'b0, head_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      shift_q     <= '0;
      halves_q    <= '0;
      busy_q      <= 1'b0;
      line_q      <= 1'b1;
      tick_q      <= '0;
      hbt_q       <= HALF_BIT_TICKS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      shift_q  <= shift_d;
      halves_q <= halves_d;
      busy_q   <= busy_d;
      line_q   <= line_d;
      tick_q   <= tick_d;
      if (cfg_we_i) begin
        hbt_q <= cfg_wdata_i;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && accept) begin
      queue_q[tail_q] <= cmd_i.data;
    end
    if (take) begin
      out_line_q  <= line_d;
      out_acc_q   <= accept;
      out_busy_q  <= busy_d;
      out_count_q <= COUNT_W'(count_full);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_level_o    = out_line_q;
  assign push_accepted_o = out_acc_q;
  assign sending_o       = out_busy_q;
  assign queued_bytes_o  = out_count_q;

  `MBT_ASSERT_ALWAYS(a_idle_queue_empty, busy_q || (head_q == tail_q), "idle with bytes queued")
  `MBT_ASSERT_ALWAYS(a_idle_no_halves, busy_q || (halves_q == '0 && tick_q == '0),
                     "idle with a byte or timer in flight")
  `MBT_ASSERT_ALWAYS(a_halves_range, halves_q <= HALVES_PER_BYTE, "half-bit count out of range")
  `MBT_ASSERT_NEXT(a_stall_hold, out_valid_q && out_stall_i,
                   out_valid_q && $stable(out_line_q) && $stable(out_count_q),
                   "result changed while stalled")

endmodule

`default_nettype wire

### dv/tb_manchester_byte_transmitter.sv
// Self-checking testbench for manchester_byte_transmitter: directed rows, then random words.
// Depends on mbt_pkg and the RTL only. Results are scored against typed directed rows or a behavioral line model.
module tb_manchester_byte_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  import mbt_pkg::*;

  typedef struct packed {
    logic               line;
    logic               accepted;
    logic               busy;
    logic [COUNT_W-1:0] queued;
  } tx_status_t;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic              typed;
    tx_status_t        status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;
  localparam int NUM_PHASES    = 8;
  localparam int PIPE_SLACK    = 8;
  localparam int LONG_HOLD     = 200;

  localparam int PHASE_TICKS [NUM_PHASES] = '{1, 0, 2, 3, 65535, 5, 487, 1};
  localparam int PHASE_WORDS [NUM_PHASES] = '{220, 100, 150, 120, 60, 150, 60, 160};
  localparam int PUSH_MIX [4] = '{3, 10, 35, 80};

  // Runs under the reset value of half_bit_ticks: fills the queue, then overflows it.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_TICK, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 4'd0}},
    '{OP_PUSH, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b1, 4'd0}},
    '{OP_TICK, 8'h5A, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd0}},
    '{OP_PUSH, 8'hFF, 1'b0, '0},
    '{OP_PUSH, 8'h01, 1'b0, '0},
    '{OP_PUSH, 8'h80, 1'b0, '0},
    '{OP_PUSH, 8'h55, 1'b0, '0},
    '{OP_PUSH, 8'hAA, 1'b0, '0},
    '{OP_PUSH, 8'h0F, 1'b0, '0},
    '{OP_PUSH, 8'hF0, 1'b0, '0},
    '{OP_PUSH, 8'h33, 1'b0, '0},
    '{OP_PUSH, 8'hCC, 1'b0, '0},
    '{OP_PUSH, 8'h96, 1'b0, '0},
    '{OP_PUSH, 8'h69, 1'b0, '0},
    '{OP_PUSH, 8'hFE, 1'b0, '0},
    '{OP_PUSH, 8'h7E, 1'b0, '0},
    '{OP_PUSH, 8'h81, 1'b0, '0},
    '{OP_PUSH, 8'h7F, 1'b1, '{1'b0, 1'b1, 1'b1, 4'd15}},
    '{OP_PUSH, 8'hC3, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd15}},
    '{OP_TICK, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd15}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [TICK_W-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  op_e                op_drv = OP_TICK;
  logic [DATA_W-1:0]  data_drv = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               line_level;
  logic               push_accepted;
  logic               sending;
  logic [COUNT_W-1:0] queued_bytes;

  tx_status_t pending_status [$];
  bit         failed = 1'b0;

  // Line model state.
  logic [DATA_W-1:0]   tx_fifo [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   fifo_rd = '0;
  logic [QPTR_W-1:0]   fifo_wr = '0;
  logic [DATA_W-1:0]   shifter = '0;
  logic [HALVES_W-1:0] halves_due = '0;
  logic                tx_busy = 1'b0;
  logic                tx_line = 1'b1;
  logic [TICK_W-1:0]   tick_cnt = '0;
  logic [TICK_W-1:0]   slot_ticks = HALF_BIT_TICKS_RESET;

  manchester_byte_transmitter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (op_drv),
    .data_byte_i     (data_drv),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .line_level_o    (line_level),
    .push_accepted_o (push_accepted),
    .sending_o       (sending),
    .queued_bytes_o  (queued_bytes)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // One half-bit slot: drive a half-bit, load the next byte with the line held, or go idle when the queue is empty.
  function automatic void serialize_slot();
    if (halves_due != '0) begin
      if (!halves_due[0]) begin
        tx_line = ~shifter[0];
      end else begin
        tx_line = shifter[0];
        shifter = shifter >> 1;
      end
      halves_due = halves_due - 1'b1;
    end else if (fifo_rd == fifo_wr) begin
      tx_busy = 1'b0;
    end else begin
      shifter    = tx_fifo[fifo_rd];
      fifo_rd    = ptr_inc(fifo_rd);
      halves_due = HALVES_PER_BYTE;
    end
  endfunction

  function automatic tx_status_t tx_advance(input op_e op, input logic [DATA_W-1:0] data);
    tx_status_t        s;
    logic [QPTR_W-1:0] nxt;
    s = '0;
    if (op == OP_PUSH) begin
      nxt = ptr_inc(fifo_wr);
      if (nxt != fifo_rd) begin
        tx_fifo[fifo_wr] = data;
        fifo_wr          = nxt;
        s.accepted       = 1'b1;
      end
      if (!tx_busy) begin
        tx_busy    = 1'b1;
        tx_line    = ~tx_line;
        halves_due = '0;
        tick_cnt   = '0;
        serialize_slot();
      end
    end else if (tx_busy) begin
      tick_cnt = tick_cnt + 1'b1;
      // A zero setting behaves like one: every tick ends a slot.
      if (tick_cnt >= slot_ticks) begin
        tick_cnt = '0;
        serialize_slot();
      end
    end
    s.line   = tx_line;
    s.busy   = tx_busy;
    s.queued = COUNT_W'((int'(fifo_wr) + QUEUE_DEPTH - int'(fifo_rd)) % QUEUE_DEPTH);
    return s;
  endfunction

  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  task automatic drive_word(input op_e op, input logic [DATA_W-1:0] data,
                            input logic typed, input tx_status_t typed_status);
    tx_status_t predicted;
    in_valid <= 1'b1;
    op_drv   <= op;
    data_drv <= data;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = tx_advance(op, data);
    pending_status.push_back(typed ? typed_status : predicted);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  task automatic write_slot_ticks(input logic [TICK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    slot_ticks = value;
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int gap;
    int push_pct;
    int sender_mode;
    gap = 0;
    push_pct = PUSH_MIX[0];
    sender_mode = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                 directed_rows[i].status);
      gap = draw_gap((i / 7) % 3);
      if (gap != 0 || i == DIRECTED_ROWS - 1) pause_sender(gap);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_slot_ticks(TICK_W'(PHASE_TICKS[p]));
      for (int i = 0; i < PHASE_WORDS[p]; i++) begin
        if (i % 50 == 0) sender_mode = $urandom_range(0, 2);
        if (i % 40 == 0) push_pct = PUSH_MIX[$urandom_range(0, 3)];
        drive_word(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TICK,
                   DATA_W'($urandom_range(0, 255)), 1'b0, '0);
        gap = draw_gap(sender_mode);
        if (gap != 0 || i == PHASE_WORDS[p] - 1 || (p == 0 && i == 120)) pause_sender(gap);
        // Hold the sender once until every outstanding word has come back.
        if (p == 0 && i == 120) wait_drained();
      end
    end

    wait_drained();
    if (!failed && pending_status.size() == 0) begin
      $display("manchester_byte_transmitter verification clean");
    end else begin
      $display("manchester_byte_transmitter verification failed");
    end
    $finish;
  end

  initial begin
    int         hold;
    int         recv_mode;
    int         results_seen;
    tx_status_t want;
    tx_status_t got;
    recv_mode    = 0;
    results_seen = 0;
    forever begin
      if (results_seen % 64 == 0) recv_mode = $urandom_range(0, 2);
      // Two long hold-offs back the block up until it stalls its input.
      hold = (results_seen == 300 || results_seen == 750) ? LONG_HOLD : draw_gap(recv_mode);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      results_seen++;
      got = '{line_level, push_accepted, sending, queued_bytes};
      if (pending_status.size() == 0) begin
        failed = 1'b1;
        $display("%0t ns: unexpected word, expected none, got line %b acc %b busy %b queued %0d",
                 $time, got.line, got.accepted, got.busy, got.queued);
      end else begin
        want = pending_status.pop_front();
        if (got.line !== want.line || got.accepted !== want.accepted ||
            got.busy !== want.busy || got.queued !== want.queued) begin
          failed = 1'b1;
          $display("%0t ns: mismatch, expected line %b acc %b busy %b queued %0d, got %b %b %b %0d",
                   $time, want.line, want.accepted, want.busy, want.queued,
                   got.line, got.accepted, got.busy, got.queued);
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("manchester_byte_transmitter verification failed");
    $finish;
  end

endmodule
